[src/lsmmpq_pkg.sv]
// Shared types, widths and codes of the linear scan min/max priority queue.
package lsmmpq_pkg;

    localparam int LSMMPQ_DEPTH = 128;
    localparam int DATA_W       = 32;
    localparam int SIZE_W       = 8;
    localparam int CAP_W        = 8;

    typedef enum logic [1:0] {
        CMD_INS_DATA = 2'd0,
        CMD_INS_PRIO = 2'd1,
        CMD_EXT_MIN  = 2'd2,
        CMD_EXT_MAX  = 2'd3
    } t_cmd;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] data_out;
        logic [SIZE_W-1:0]        size;
    } t_out_item;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
    } t_cfg_item;

endpackage

[src/lsmmpq_chan.sv]
// Valid/ready channel interface carrying one item of a chosen payload type.
interface lsmmpq_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[src/linear_scan_min_max_priority_queue.sv]
// Top level of the linear scan min/max priority queue.
//
// The queue holds up to DEPTH (data, priority) pairs in an unsorted on-chip memory; the
// capacity register limits how many are used and any write to it empties the queue.
// Insert commands, and every refused request, finish without leaving the idle state, so
// such items can be taken in every cycle while results are drained. An extract-min or
// extract-max reads the held entries one per cycle through the single memory read port
// into one shared signed comparator, then swaps the picked entry with the last one in
// the write states S_WR_BEST and S_WR_LAST, and no item is taken meanwhile.
// Ties go to the lowest index. No clearing pass is needed after reset.
module linear_scan_min_max_priority_queue
    import lsmmpq_pkg::*;
#(
    parameter int DEPTH = LSMMPQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsmmpq_chan.sink    i_cfg,
    lsmmpq_chan.sink    i_in,
    lsmmpq_chan.source  o_out
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW   = $clog2(DEPTH + 1);
    localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_LAST    = 5'b00100,
        S_WR_BEST = 5'b01000,
        S_WR_LAST = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_last, n_last;
    t_cmd              r_cmd, n_cmd;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    logic signed [DATA_W-1:0] data_mem [DEPTH];
    logic signed [DATA_W-1:0] prio_mem [DEPTH];

    logic                     r_rd_vld;
    logic [AW-1:0]            r_rd_idx;
    logic signed [DATA_W-1:0] r_rd_d, r_rd_p;
    logic [AW-1:0]            r_best_idx;
    logic signed [DATA_W-1:0] r_best_d, r_best_p;
    logic signed [DATA_W-1:0] r_last_d, r_last_p;

    logic                     data_we, prio_we;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_d, wr_p;

    logic            in_acc;
    logic            cfg_acc;
    logic [CMPW-1:0] cap_eff;
    logic            better;

    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_vld || o_out.ready);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign cap_eff = (CMPW'(r_cap) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(r_cap);

    assign better = (r_cmd == CMD_EXT_MIN) ? (r_rd_p < r_best_p) : (r_best_p < r_rd_p);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_last    = r_last;
        n_cmd     = r_cmd;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out     = r_out;
        data_we   = 1'b0;
        prio_we   = 1'b0;
        wr_addr   = AW'(r_fill);
        wr_d      = i_in.data.value;
        wr_p      = i_in.data.value;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_vld      = 1'b1;
                    n_out.status   = ST_REFUSED;
                    n_out.data_out = '0;
                    n_out.size     = SIZE_W'(r_fill);
                    if (cap_eff != '0) begin
                        if (i_in.data.cmd inside {CMD_INS_DATA, CMD_INS_PRIO}) begin
                            if (CMPW'(r_fill) < cap_eff) begin
                                n_out.status = ST_OK;
                                if (i_in.data.cmd == CMD_INS_DATA) begin
                                    data_we = 1'b1;
                                end else begin
                                    prio_we    = 1'b1;
                                    n_fill     = FW'(r_fill + 1'b1);
                                    n_out.size = SIZE_W'(r_fill + 1'b1);
                                end
                            end
                        end else if (r_fill != '0) begin
                            n_out_vld = 1'b0;
                            n_state   = S_SCAN;
                            n_idx     = '0;
                            n_last    = AW'(r_fill - 1'b1);
                            n_cmd     = i_in.data.cmd;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_idx = AW'(r_idx + 1'b1);
                if (r_idx == r_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WR_BEST;
            end
            S_WR_BEST: begin
                data_we = 1'b1;
                prio_we = 1'b1;
                wr_addr = r_best_idx;
                wr_d    = r_last_d;
                wr_p    = r_last_p;
                n_state = S_WR_LAST;
            end
            S_WR_LAST: begin
                data_we        = 1'b1;
                prio_we        = 1'b1;
                wr_addr        = r_last;
                wr_d           = r_best_d;
                wr_p           = r_best_p;
                n_fill         = FW'(r_last);
                n_out_vld      = 1'b1;
                n_out.status   = ST_OK;
                n_out.data_out = r_best_d;
                n_out.size     = SIZE_W'(r_last);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_state == S_SCAN);
            if (cfg_acc) begin
                r_cap  <= i_cfg.data.capacity;
                r_fill <= '0;
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_cmd    <= n_cmd;
        r_out    <= n_out;
        r_rd_idx <= r_idx;
        if (r_rd_vld) begin
            if ((r_rd_idx == '0) || better) begin
                r_best_idx <= r_rd_idx;
                r_best_d   <= r_rd_d;
                r_best_p   <= r_rd_p;
            end
            if (r_rd_idx == r_last) begin
                r_last_d <= r_rd_d;
                r_last_p <= r_rd_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[wr_addr] <= wr_d;
        end
        if (prio_we) begin
            prio_mem[wr_addr] <= wr_p;
        end
        if (r_state == S_SCAN) begin
            r_rd_d <= data_mem[r_idx];
            r_rd_p <= prio_mem[r_idx];
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("Input taken while an extract is in progress.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_fill) <= CMPW'(DEPTH)))
        else $error("Fill count exceeds the memory depth.");

    a_extract_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_LAST) |=> (r_out_vld && (r_out.status == ST_OK)))
        else $error("Finished extract did not load a result.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_last))
        else $error("Scan index ran past the last held entry.");

endmodule
